// File: hw/rtl/cft_pkg.sv
// Package for the CSV field tokenizer: payload structs, event kinds,
// character codes and configuration register indexes.
// No dependencies; every other file of the block imports it.
`default_nettype none

package cft_pkg;

    // Default depth of the held whitespace store.
    localparam int SPACE_DEPTH_DEF = 8;

    // Configuration port widths and register indexes.
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_SKIP_FIRST_ROW  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_SKIP_BLANK_ROWS = 1'b1;

    // Input operation codes.
    localparam logic OP_DATA = 1'b0;
    localparam logic OP_EOF  = 1'b1;

    // Result kinds.
    localparam logic [1:0] K_BYTE  = 2'd0;
    localparam logic [1:0] K_FIELD = 2'd1;
    localparam logic [1:0] K_ROW   = 2'd2;
    localparam logic [1:0] K_EOF   = 2'd3;

    // Character codes.
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;

    // One input transaction.
    typedef struct packed {
        logic       op;
        logic [7:0] data_byte;
    } in_t;

    // One result transaction.
    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] out_byte;
        logic       syntax_error;
        logic       space_overflow;
        logic       last;
    } out_t;

    // Fixed-order events raised by one input, after any flushed whitespace.
    typedef struct packed {
        logic       byte_en;
        logic [7:0] byte_val;
        logic       field_en;
        logic       row_en;
        logic       eof_en;
        logic       err;
        logic       ovf;
    } evt_t;

endpackage

`default_nettype wire

// File: hw/rtl/cft_parser.sv
// Parse state machine of the CSV field tokenizer: configuration registers,
// held whitespace store and the decode of one input into its events.
// Depends on cft_pkg.
`default_nettype none

module cft_parser
    import cft_pkg::*;
#(
    parameter int SPACE_DEPTH = SPACE_DEPTH_DEF,
    parameter int CW          = $clog2(SPACE_DEPTH + 1),
    parameter int IW          = (SPACE_DEPTH > 1) ? $clog2(SPACE_DEPTH) : 1
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_fire,
    input  wire in_t                   in_item,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    input  wire logic [IW-1:0]         rd_idx,
    output logic [7:0]                 rd_byte,
    output evt_t                       evt,
    output logic [CW-1:0]              flush_n
);

    localparam logic [2:0] ST_BEFORE  = 3'd0;
    localparam logic [2:0] ST_FIELD   = 3'd1;
    localparam logic [2:0] ST_QUOTE   = 3'd2;
    localparam logic [2:0] ST_ONQUOTE = 3'd3;
    localparam logic [2:0] ST_AFTER   = 3'd4;
    localparam logic [2:0] ST_SKIP    = 3'd5;

    logic [2:0]    state_reg, state_next;
    logic [CW-1:0] held_count_reg, held_count_next;
    logic          row_has_field_reg, row_has_field_next;
    logic          error_seen_reg, error_seen_next;
    logic          overflow_seen_reg, overflow_seen_next;
    logic          at_start_reg, at_start_next;
    logic          skip_first_row_reg;
    logic          skip_blank_rows_reg;
    logic [7:0]    held_space [SPACE_DEPTH];
    logic          held_we;
    logic          err_mid;

    logic       is_eof, is_q, is_comma, is_nl, is_ws;
    logic [7:0] ch;

    // Character classes of the incoming byte.
    assign is_eof   = (in_item.op == OP_EOF);
    assign ch       = in_item.data_byte;
    assign is_q     = (ch == CH_QUOTE);
    assign is_comma = (ch == CH_COMMA);
    assign is_nl    = (ch == CH_NL);
    assign is_ws    = (ch == CH_SPACE) || (ch == CH_TAB) || (ch == CH_CR);

    // Next state and events for the input on the port.
    always_comb
    begin
        state_next         = state_reg;
        held_count_next    = held_count_reg;
        row_has_field_next = row_has_field_reg;
        err_mid            = error_seen_reg;
        overflow_seen_next = overflow_seen_reg;
        at_start_next      = is_eof ? at_start_reg : 1'b0;
        held_we            = 1'b0;
        flush_n            = '0;
        evt                = '0;

        unique case (state_reg)
            ST_SKIP:
            begin
                if (is_eof)
                begin
                    evt.eof_en = 1'b1;
                end
                else if (is_nl)
                begin
                    state_next         = ST_BEFORE;
                    row_has_field_next = 1'b0;
                end
            end
            ST_BEFORE:
            begin
                if (is_eof)
                begin
                    evt.row_en = row_has_field_reg;
                    evt.eof_en = 1'b1;
                end
                else if (is_q)
                begin
                    row_has_field_next = 1'b1;
                    state_next         = ST_QUOTE;
                end
                else if (is_comma)
                begin
                    row_has_field_next = 1'b1;
                    evt.field_en       = 1'b1;
                end
                else if (is_ws)
                begin
                    // Leading whitespace is dropped.
                end
                else if (is_nl)
                begin
                    if (!(skip_blank_rows_reg && !row_has_field_reg))
                    begin
                        evt.field_en = 1'b1;
                        evt.row_en   = 1'b1;
                    end
                    row_has_field_next = 1'b0;
                end
                else
                begin
                    row_has_field_next = 1'b1;
                    evt.byte_en        = 1'b1;
                    state_next         = ST_FIELD;
                end
            end
            ST_FIELD:
            begin
                if (is_eof)
                begin
                    held_count_next = '0;
                    evt.field_en    = 1'b1;
                    evt.row_en      = 1'b1;
                    evt.eof_en      = 1'b1;
                end
                else if (is_q)
                begin
                    err_mid         = 1'b1;
                    flush_n         = held_count_reg;
                    held_count_next = '0;
                    state_next      = ST_QUOTE;
                end
                else if (is_comma)
                begin
                    held_count_next = '0;
                    evt.field_en    = 1'b1;
                    state_next      = ST_BEFORE;
                end
                else if (is_ws)
                begin
                    // Inner whitespace is held until a later ordinary byte or quote flushes it.
                    if (held_count_reg < CW'(SPACE_DEPTH))
                    begin
                        held_we         = 1'b1;
                        held_count_next = held_count_reg + CW'(1);
                    end
                    else
                    begin
                        overflow_seen_next = 1'b1;
                    end
                end
                else if (is_nl)
                begin
                    held_count_next    = '0;
                    evt.field_en       = 1'b1;
                    evt.row_en         = 1'b1;
                    row_has_field_next = 1'b0;
                    state_next         = ST_BEFORE;
                end
                else
                begin
                    flush_n         = held_count_reg;
                    held_count_next = '0;
                    evt.byte_en     = 1'b1;
                end
            end
            ST_QUOTE:
            begin
                if (is_eof)
                begin
                    err_mid      = 1'b1;
                    evt.field_en = 1'b1;
                    evt.row_en   = 1'b1;
                    evt.eof_en   = 1'b1;
                end
                else if (is_q)
                begin
                    state_next = ST_ONQUOTE;
                end
                else
                begin
                    evt.byte_en = 1'b1;
                end
            end
            ST_ONQUOTE:
            begin
                if (is_eof)
                begin
                    evt.field_en = 1'b1;
                    evt.row_en   = 1'b1;
                    evt.eof_en   = 1'b1;
                end
                else if (is_q)
                begin
                    // A doubled quote stands for one quote character.
                    evt.byte_en = 1'b1;
                    state_next  = ST_QUOTE;
                end
                else if (is_comma)
                begin
                    evt.field_en = 1'b1;
                    state_next   = ST_BEFORE;
                end
                else if (is_nl)
                begin
                    evt.field_en       = 1'b1;
                    evt.row_en         = 1'b1;
                    row_has_field_next = 1'b0;
                    state_next         = ST_BEFORE;
                end
                else if (is_ws)
                begin
                    evt.field_en = 1'b1;
                    state_next   = ST_AFTER;
                end
                else
                begin
                    // Garbage after a closing quote ends the field and the row.
                    err_mid            = 1'b1;
                    evt.field_en       = 1'b1;
                    evt.row_en         = 1'b1;
                    row_has_field_next = 1'b0;
                    state_next         = ST_AFTER;
                end
            end
            ST_AFTER:
            begin
                if (is_eof)
                begin
                    evt.row_en = 1'b1;
                    evt.eof_en = 1'b1;
                end
                else if (is_ws)
                begin
                    // Dropped.
                end
                else if (is_comma)
                begin
                    state_next = ST_BEFORE;
                end
                else if (is_nl)
                begin
                    evt.row_en         = 1'b1;
                    row_has_field_next = 1'b0;
                    state_next         = ST_BEFORE;
                end
                else
                begin
                    err_mid = 1'b1;
                end
            end
            default:
            begin
                state_next = ST_BEFORE;
            end
        endcase

        evt.byte_val = evt.byte_en ? ch : 8'h00;
        evt.err      = err_mid;
        evt.ovf      = overflow_seen_next;

        // End of input restarts the parser and clears the error flag.
        error_seen_next = err_mid;
        if (is_eof)
        begin
            error_seen_next    = 1'b0;
            state_next         = skip_first_row_reg ? ST_SKIP : ST_BEFORE;
            held_count_next    = '0;
            row_has_field_next = 1'b0;
            at_start_next      = 1'b1;
        end
    end

    // Parser control registers and configuration.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg           <= ST_BEFORE;
            held_count_reg      <= '0;
            row_has_field_reg   <= 1'b0;
            error_seen_reg      <= 1'b0;
            overflow_seen_reg   <= 1'b0;
            at_start_reg        <= 1'b1;
            skip_first_row_reg  <= 1'b0;
            skip_blank_rows_reg <= 1'b0;
        end
        else
        begin
            if (in_fire)
            begin
                state_reg         <= state_next;
                held_count_reg    <= held_count_next;
                row_has_field_reg <= row_has_field_next;
                error_seen_reg    <= error_seen_next;
                overflow_seen_reg <= overflow_seen_next;
                at_start_reg      <= at_start_next;
            end
            else if (cfg_we && (cfg_index == REG_SKIP_FIRST_ROW) && at_start_reg)
            begin
                // Before any data the skip setting takes effect at once.
                state_reg <= cfg_data[0] ? ST_SKIP : ST_BEFORE;
            end

            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_SKIP_FIRST_ROW:  skip_first_row_reg  <= cfg_data[0];
                    REG_SKIP_BLANK_ROWS: skip_blank_rows_reg <= cfg_data[0];
                    default:             ;
                endcase
            end
        end
    end

    // Held whitespace store. The read is registered: rd_idx is the address
    // that the flush needs in the following cycle.
    always_ff @(posedge clk)
    begin
        if (in_fire && held_we)
        begin
            held_space[held_count_reg[IW-1:0]] <= ch;
        end
        rd_byte <= held_space[rd_idx];
    end

    // The held count never passes the store depth.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        held_count_reg <= CW'(SPACE_DEPTH))
        else $error("held whitespace count beyond store depth");

    // Only the field state holds whitespace.
    a_count_in_field: assert property (@(posedge clk) disable iff (!rst_n)
        held_count_reg != '0 |-> state_reg == ST_FIELD)
        else $error("whitespace held outside an unquoted field");

endmodule

`default_nettype wire

// File: hw/rtl/csv_field_tokenizer_top.sv
// Top level of the CSV field tokenizer: input handshake, result register
// that sequences the events of one input, and the output handshake.
// Depends on cft_pkg and cft_parser.
// Latency: the first result of an input is offered the cycle after it is taken.
// Throughput: one input per cycle while each input yields at most one result and
// no result stalls; an input with more results (up to SPACE_DEPTH + 1, or 3 at
// end of input in a field) stalls the input side until its last result is taken.
// Reset (rst_n, asynchronous): result register emptied, parser at the start state.
`default_nettype none

module csv_field_tokenizer_top
    import cft_pkg::*;
#(
    parameter int SPACE_DEPTH = SPACE_DEPTH_DEF
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  byte_valid,
    output logic                       byte_stall,
    input  wire in_t                   byte_item,
    output logic                       tok_valid,
    input  wire logic                  tok_stall,
    output out_t                       tok_item,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int CW = $clog2(SPACE_DEPTH + 1);
    localparam int IW = (SPACE_DEPTH > 1) ? $clog2(SPACE_DEPTH) : 1;

    evt_t          evt;
    logic [CW-1:0] flush_n;
    logic [7:0]    rd_byte;

    // Result register: remaining flush bytes and the fixed-order events.
    logic [CW-1:0] flush_rem_reg;
    logic [IW-1:0] flush_idx_reg, flush_idx_next;
    logic          byte_en_reg, field_en_reg, row_en_reg, eof_en_reg;
    logic [7:0]    byte_val_reg;
    logic          err_reg, ovf_reg;

    logic       byte_fire, tok_fire, tok_last;
    logic [2:0] tail_n;

    cft_parser #(
        .SPACE_DEPTH (SPACE_DEPTH),
        .CW          (CW),
        .IW          (IW)
    ) u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_fire   (byte_fire),
        .in_item   (byte_item),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .rd_idx    (flush_idx_next),
        .rd_byte   (rd_byte),
        .evt       (evt),
        .flush_n   (flush_n)
    );

    // Handshake and end of the current result sequence.
    assign tail_n = {2'b00, byte_en_reg} + {2'b00, field_en_reg}
                  + {2'b00, row_en_reg} + {2'b00, eof_en_reg};
    assign tok_valid  = (flush_rem_reg != '0) || (tail_n != 3'd0);
    assign tok_last   = ((flush_rem_reg == '0) && (tail_n == 3'd1))
                     || ((flush_rem_reg == CW'(1)) && (tail_n == 3'd0));
    assign tok_fire   = tok_valid && !tok_stall;
    assign byte_stall = tok_valid && !(tok_fire && tok_last);
    assign byte_fire  = byte_valid && !byte_stall;

    // Result transaction selection: flushed whitespace first, then events.
    always_comb
    begin
        tok_item                = '0;
        tok_item.syntax_error   = err_reg;
        tok_item.space_overflow = ovf_reg;
        tok_item.last           = tok_last;
        if (flush_rem_reg != '0)
        begin
            tok_item.kind     = K_BYTE;
            tok_item.out_byte = rd_byte;
        end
        else if (byte_en_reg)
        begin
            tok_item.kind     = K_BYTE;
            tok_item.out_byte = byte_val_reg;
        end
        else if (field_en_reg)
        begin
            tok_item.kind = K_FIELD;
        end
        else if (row_en_reg)
        begin
            tok_item.kind = K_ROW;
        end
        else
        begin
            tok_item.kind = K_EOF;
        end
    end

    // Flush read address: back to the first entry on a taken input, then one
    // step per taken flush byte.
    always_comb
    begin
        flush_idx_next = flush_idx_reg;
        if (byte_fire)
        begin
            flush_idx_next = '0;
        end
        else if (tok_fire && (flush_rem_reg != '0))
        begin
            flush_idx_next = flush_idx_reg + IW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flush_idx_reg <= '0;
        end
        else
        begin
            flush_idx_reg <= flush_idx_next;
        end
    end

    // Load on a taken input, otherwise step past each taken result.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flush_rem_reg <= '0;
            byte_en_reg   <= 1'b0;
            field_en_reg  <= 1'b0;
            row_en_reg    <= 1'b0;
            eof_en_reg    <= 1'b0;
        end
        else if (byte_fire)
        begin
            flush_rem_reg <= flush_n;
            byte_en_reg   <= evt.byte_en;
            field_en_reg  <= evt.field_en;
            row_en_reg    <= evt.row_en;
            eof_en_reg    <= evt.eof_en;
        end
        else if (tok_fire)
        begin
            if (flush_rem_reg != '0)
            begin
                flush_rem_reg <= flush_rem_reg - CW'(1);
            end
            else if (byte_en_reg)
            begin
                byte_en_reg <= 1'b0;
            end
            else if (field_en_reg)
            begin
                field_en_reg <= 1'b0;
            end
            else if (row_en_reg)
            begin
                row_en_reg <= 1'b0;
            end
            else
            begin
                eof_en_reg <= 1'b0;
            end
        end
    end

    // Result payload, taken with each input.
    always_ff @(posedge clk)
    begin
        if (byte_fire)
        begin
            byte_val_reg <= evt.byte_val;
            err_reg      <= evt.err;
            ovf_reg      <= evt.ovf;
        end
    end

    // End of input is always the final result of its input.
    a_eof_last: assert property (@(posedge clk) disable iff (!rst_n)
        tok_valid && (tok_item.kind == K_EOF) |-> tok_item.last)
        else $error("end-of-input result not marked last");

    // Events other than field bytes carry a zero byte.
    a_byte_zero: assert property (@(posedge clk) disable iff (!rst_n)
        tok_valid && (tok_item.kind != K_BYTE) |-> tok_item.out_byte == 8'h00)
        else $error("non-byte result carries a byte value");

    // An input that raises events offers its first result on the next cycle.
    a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
        byte_fire && ((flush_n != '0) || evt.byte_en || evt.field_en
            || evt.row_en || evt.eof_en) |=> tok_valid)
        else $error("events of a taken input were lost");

    // The flush count never passes the store depth.
    a_flush_bound: assert property (@(posedge clk) disable iff (!rst_n)
        flush_rem_reg <= CW'(SPACE_DEPTH))
        else $error("flush count beyond store depth");

endmodule

`default_nettype wire
